[src/asw_pkg.sv]
// shared types, constants and codes for the aligned segment cell walk
package asw_pkg;

    // fixed field widths
    localparam int COORD_W      = 32;
    localparam int SIZE_W       = 31;
    localparam int IDX_W        = 6;
    localparam int FRAC_OUT_W   = 17;
    localparam int CFG_IDX_W    = 3;

    // internal arithmetic widths: walls and ratio operands, divider quotient
    localparam int CW           = 40;
    localparam int DW           = 40;
    localparam int QW           = COORD_W + 1;
    localparam int STEP_W       = 6;
    localparam int PROD_W       = IDX_W + SIZE_W;

    // parameter defaults
    localparam int GRID_DIM_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_MIN_X  = 3'd0,
        REG_GRID_MIN_Y  = 3'd1,
        REG_GRID_MIN_Z  = 3'd2,
        REG_CELL_SIZE_X = 3'd3,
        REG_CELL_SIZE_Y = 3'd4,
        REG_CELL_SIZE_Z = 3'd5
    } reg_idx_t;

    // axis codes
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // ratio slots
    localparam logic [1:0] RAT_INSIDE = 2'd0;
    localparam logic [1:0] RAT_UPPER  = 2'd1;
    localparam logic [1:0] RAT_LOWER  = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
        logic [1:0]                axis_sel;
    } in_t;

    typedef struct packed {
        logic [IDX_W-1:0]      cell_i;
        logic [IDX_W-1:0]      cell_j;
        logic [IDX_W-1:0]      cell_k;
        logic [FRAC_OUT_W-1:0] inside_fraction;
        logic [FRAC_OUT_W-1:0] upper_wall_fraction;
        logic [FRAC_OUT_W-1:0] lower_wall_fraction;
        logic                  last_cell;
    } out_t;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DW-1:0]     rem0;
        logic [QW-1:0]     dvd;
        logic [DW-1:0]     dsr;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDX_PREP,
        ST_IDX_DIV,
        ST_RANGE,
        ST_MUL,
        ST_WALL,
        ST_R_PREP,
        ST_R_ABS,
        ST_R_CHK,
        ST_R_DIV,
        ST_OUT
    } state_t;

endpackage

[src/asw_div.sv]
// shared restoring divider, one quotient bit per cycle
module asw_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  asw_pkg::div_req_t req,
    output asw_pkg::div_rsp_t rsp
);

    logic [asw_pkg::DW-1:0]     rem_reg, rem_next;
    logic [asw_pkg::QW-1:0]     q_reg, q_next;
    logic [asw_pkg::DW-1:0]     d_reg, d_next;
    logic [asw_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [asw_pkg::DW:0]       trial;
    logic [asw_pkg::DW:0]       diff;
    logic                       ge;

    // one trial subtraction per step
    assign trial = {rem_reg, q_reg[asw_pkg::QW-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign ge    = (trial >= {1'b0, d_reg});

    always_comb begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.rem0;
            q_next    = req.dvd;
            d_next    = req.dsr;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[asw_pkg::DW-1:0] : trial[asw_pkg::DW-1:0];
            q_next   = {q_reg[asw_pkg::QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == asw_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = q_reg;

endmodule

[src/aligned_segment_cell_walk_top.sv]
// top level: register file, walk sequencer and shared divider
// Walks an axis-aligned segment through a uniform grid and returns one request per cell
// along the chosen axis, from the lower end index to the higher one. One segment is
// taken at a time: s_ready is high only while the block is idle. The four end indices
// (three at the start point, one at the end point on the axis) are found on the shared
// divider, and each cell then waits for m_ready after its three fractions have gone one
// after another through the same bit-serial divider, where a division is needed.
// A segment with axis code 3 is taken, returns nothing and leaves the block idle.
module aligned_segment_cell_walk_top #(
    parameter int GRID_DIM  = asw_pkg::GRID_DIM_DEF,
    parameter int FRAC_BITS = asw_pkg::FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [asw_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [asw_pkg::COORD_W-1:0]     cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  asw_pkg::in_t                    s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output asw_pkg::out_t                   m_data
);

    localparam int RW = FRAC_BITS + 1;

    asw_pkg::state_t state_reg, state_next;

    logic signed [asw_pkg::COORD_W-1:0] gmin_reg [3];
    logic [asw_pkg::SIZE_W-1:0]         size_reg [3];
    logic signed [asw_pkg::COORD_W-1:0] s_reg [3];
    logic signed [asw_pkg::COORD_W-1:0] e_reg [3];
    logic [1:0]                         axis_reg, axis_next;
    logic [asw_pkg::IDX_W-1:0]          sid_reg [3];
    logic [asw_pkg::IDX_W-1:0]          eid_reg;
    logic [1:0]                         k_reg, k_next;
    logic [1:0]                         r_reg, r_next;
    logic [asw_pkg::IDX_W-1:0]          lo_c_reg, lo_c_next;
    logic [asw_pkg::IDX_W-1:0]          hi_c_reg, hi_c_next;
    logic [asw_pkg::IDX_W-1:0]          c_reg, c_next;
    logic [asw_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic signed [asw_pkg::CW-1:0]      w1_reg, w1_next;
    logic signed [asw_pkg::CW-1:0]      w2_reg, w2_next;
    logic signed [asw_pkg::CW-1:0]      num_reg, num_next;
    logic signed [asw_pkg::CW-1:0]      den_reg, den_next;
    logic [asw_pkg::DW-1:0]             un_reg, un_next;
    logic [asw_pkg::DW-1:0]             ud_reg, ud_next;
    logic                               zero_reg, zero_next;
    logic [RW-1:0]                      frac_reg [3];

    logic                               idx_we;
    logic [asw_pkg::IDX_W-1:0]          idx_val;
    logic                               frac_we;
    logic [RW-1:0]                      frac_val;

    asw_pkg::div_req_t                  div_req;
    asw_pkg::div_rsp_t                  div_rsp;

    // selections for the index divisions and the walk axis
    logic [1:0]                         ax_k;
    logic signed [asw_pkg::COORD_W-1:0] p_k;
    logic signed [asw_pkg::COORD_W:0]   off_k;
    logic [asw_pkg::SIZE_W-1:0]         sz_k;
    logic [asw_pkg::SIZE_W-1:0]         sz_a;
    logic signed [asw_pkg::CW-1:0]      s_a, e_a, lo_a, hi_a;
    logic [asw_pkg::IDX_W-1:0]          sid_a;
    logic [asw_pkg::QW-1:0]             q_sat;

    assign ax_k  = (k_reg == 2'd3) ? axis_reg : k_reg;
    assign p_k   = (k_reg == 2'd3) ? e_reg[axis_reg] : s_reg[k_reg];
    assign off_k = {p_k[asw_pkg::COORD_W-1], p_k}
                 - {gmin_reg[ax_k][asw_pkg::COORD_W-1], gmin_reg[ax_k]};
    assign sz_k  = (size_reg[ax_k] == '0) ? asw_pkg::SIZE_W'(1) : size_reg[ax_k];
    assign sz_a  = (size_reg[axis_reg] == '0) ? asw_pkg::SIZE_W'(1) : size_reg[axis_reg];
    assign s_a   = asw_pkg::CW'(s_reg[axis_reg]);
    assign e_a   = asw_pkg::CW'(e_reg[axis_reg]);
    assign lo_a  = (s_a < e_a) ? s_a : e_a;
    assign hi_a  = (s_a < e_a) ? e_a : s_a;
    assign sid_a = sid_reg[axis_reg];
    assign q_sat = asw_pkg::QW'(GRID_DIM - 1);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                gmin_reg[a] <= '0;
                size_reg[a] <= asw_pkg::SIZE_W'(65536);
            end
        end else if (cfg_we) begin
            case (cfg_idx)
                asw_pkg::REG_GRID_MIN_X:  gmin_reg[0] <= cfg_wdata;
                asw_pkg::REG_GRID_MIN_Y:  gmin_reg[1] <= cfg_wdata;
                asw_pkg::REG_GRID_MIN_Z:  gmin_reg[2] <= cfg_wdata;
                asw_pkg::REG_CELL_SIZE_X: size_reg[0] <= cfg_wdata[asw_pkg::SIZE_W-1:0];
                asw_pkg::REG_CELL_SIZE_Y: size_reg[1] <= cfg_wdata[asw_pkg::SIZE_W-1:0];
                asw_pkg::REG_CELL_SIZE_Z: size_reg[2] <= cfg_wdata[asw_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            asw_pkg::ST_IDLE: begin
                if (s_valid && s_data.axis_sel != asw_pkg::AXIS_NONE) begin
                    state_next = asw_pkg::ST_IDX_PREP;
                end
            end
            asw_pkg::ST_IDX_PREP: begin
                if (!off_k[asw_pkg::COORD_W]) begin
                    state_next = asw_pkg::ST_IDX_DIV;
                end else if (k_reg == 2'd3) begin
                    state_next = asw_pkg::ST_RANGE;
                end
            end
            asw_pkg::ST_IDX_DIV: begin
                if (div_rsp.done) begin
                    state_next = (k_reg == 2'd3) ? asw_pkg::ST_RANGE : asw_pkg::ST_IDX_PREP;
                end
            end
            asw_pkg::ST_RANGE:  state_next = asw_pkg::ST_MUL;
            asw_pkg::ST_MUL:    state_next = asw_pkg::ST_WALL;
            asw_pkg::ST_WALL:   state_next = asw_pkg::ST_R_PREP;
            asw_pkg::ST_R_PREP: state_next = asw_pkg::ST_R_ABS;
            asw_pkg::ST_R_ABS:  state_next = asw_pkg::ST_R_CHK;
            asw_pkg::ST_R_CHK: begin
                if (!zero_reg && un_reg < ud_reg) begin
                    state_next = asw_pkg::ST_R_DIV;
                end else begin
                    state_next = (r_reg == asw_pkg::RAT_LOWER) ? asw_pkg::ST_OUT
                                                                : asw_pkg::ST_R_PREP;
                end
            end
            asw_pkg::ST_R_DIV: begin
                if (div_rsp.done) begin
                    state_next = (r_reg == asw_pkg::RAT_LOWER) ? asw_pkg::ST_OUT
                                                                : asw_pkg::ST_R_PREP;
                end
            end
            asw_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = (c_reg == hi_c_reg) ? asw_pkg::ST_IDLE : asw_pkg::ST_MUL;
                end
            end
            default: state_next = asw_pkg::ST_IDLE;
        endcase
    end

    // datapath and divider control
    always_comb begin
        axis_next = axis_reg;
        k_next    = k_reg;
        r_next    = r_reg;
        lo_c_next = lo_c_reg;
        hi_c_next = hi_c_reg;
        c_next    = c_reg;
        prod_next = prod_reg;
        w1_next   = w1_reg;
        w2_next   = w2_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        un_next   = un_reg;
        ud_next   = ud_reg;
        zero_next = zero_reg;
        idx_we    = 1'b0;
        idx_val   = '0;
        frac_we   = 1'b0;
        frac_val  = '0;
        div_req   = '0;
        case (state_reg)
            asw_pkg::ST_IDLE: begin
                axis_next = s_data.axis_sel;
                k_next    = 2'd0;
            end
            asw_pkg::ST_IDX_PREP: begin
                // below the grid minimum the index is zero at once
                if (off_k[asw_pkg::COORD_W]) begin
                    idx_we  = 1'b1;
                    idx_val = '0;
                    k_next  = k_reg + 2'd1;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem0  = '0;
                    div_req.dvd   = off_k[asw_pkg::QW-1:0];
                    div_req.dsr   = asw_pkg::DW'(sz_k);
                    div_req.steps = asw_pkg::STEP_W'(asw_pkg::QW);
                end
            end
            asw_pkg::ST_IDX_DIV: begin
                if (div_rsp.done) begin
                    idx_we  = 1'b1;
                    idx_val = (div_rsp.quo > q_sat) ? asw_pkg::IDX_W'(GRID_DIM - 1)
                                                    : div_rsp.quo[asw_pkg::IDX_W-1:0];
                    k_next  = k_reg + 2'd1;
                end
            end
            asw_pkg::ST_RANGE: begin
                lo_c_next = (sid_a < eid_reg) ? sid_a : eid_reg;
                hi_c_next = (sid_a < eid_reg) ? eid_reg : sid_a;
                c_next    = (sid_a < eid_reg) ? sid_a : eid_reg;
            end
            asw_pkg::ST_MUL: begin
                prod_next = asw_pkg::PROD_W'(c_reg) * asw_pkg::PROD_W'(sz_a);
            end
            asw_pkg::ST_WALL: begin
                // cell walls along the axis
                w1_next = asw_pkg::CW'(gmin_reg[axis_reg])
                        + $signed({{(asw_pkg::CW-asw_pkg::PROD_W){1'b0}}, prod_reg});
                w2_next = asw_pkg::CW'(gmin_reg[axis_reg])
                        + $signed({{(asw_pkg::CW-asw_pkg::PROD_W){1'b0}}, prod_reg})
                        + $signed({{(asw_pkg::CW-asw_pkg::SIZE_W){1'b0}}, sz_a});
                r_next  = asw_pkg::RAT_INSIDE;
            end
            asw_pkg::ST_R_PREP: begin
                case (r_reg)
                    asw_pkg::RAT_INSIDE: begin
                        num_next = ((hi_a > w2_reg) ? w2_reg : hi_a)
                                 - ((lo_a < w1_reg) ? w1_reg : lo_a);
                        den_next = hi_a - lo_a;
                    end
                    asw_pkg::RAT_UPPER: begin
                        num_next = w2_reg - e_a;
                        den_next = s_a - e_a;
                    end
                    default: begin
                        num_next = w1_reg - e_a;
                        den_next = s_a - e_a;
                    end
                endcase
            end
            asw_pkg::ST_R_ABS: begin
                // opposite signs or a zero term clamp to zero
                zero_next = (num_reg == '0) || (den_reg == '0)
                         || ((num_reg > 0) != (den_reg > 0));
                un_next   = num_reg[asw_pkg::CW-1] ? asw_pkg::DW'(-num_reg)
                                                   : asw_pkg::DW'(num_reg);
                ud_next   = den_reg[asw_pkg::CW-1] ? asw_pkg::DW'(-den_reg)
                                                   : asw_pkg::DW'(den_reg);
            end
            asw_pkg::ST_R_CHK: begin
                if (zero_reg) begin
                    frac_we  = 1'b1;
                    frac_val = '0;
                    r_next   = r_reg + 2'd1;
                end else if (un_reg >= ud_reg) begin
                    frac_we  = 1'b1;
                    frac_val = RW'(1) << FRAC_BITS;
                    r_next   = r_reg + 2'd1;
                end else begin
                    div_req.start = 1'b1;
                    div_req.rem0  = un_reg;
                    div_req.dvd   = '0;
                    div_req.dsr   = ud_reg;
                    div_req.steps = asw_pkg::STEP_W'(FRAC_BITS);
                end
            end
            asw_pkg::ST_R_DIV: begin
                if (div_rsp.done) begin
                    frac_we  = 1'b1;
                    frac_val = div_rsp.quo[RW-1:0];
                    r_next   = r_reg + 2'd1;
                end
            end
            asw_pkg::ST_OUT: begin
                if (m_ready && c_reg != hi_c_reg) begin
                    c_next = c_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= asw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == asw_pkg::ST_IDLE && s_valid) begin
            s_reg[0] <= s_data.start_x;
            s_reg[1] <= s_data.start_y;
            s_reg[2] <= s_data.start_z;
            e_reg[0] <= s_data.end_x;
            e_reg[1] <= s_data.end_y;
            e_reg[2] <= s_data.end_z;
        end
        if (idx_we) begin
            if (k_reg == 2'd3) begin
                eid_reg <= idx_val;
            end else begin
                sid_reg[k_reg] <= idx_val;
            end
        end
        if (frac_we) begin
            frac_reg[r_reg] <= frac_val;
        end
        axis_reg <= axis_next;
        k_reg    <= k_next;
        r_reg    <= r_next;
        lo_c_reg <= lo_c_next;
        hi_c_reg <= hi_c_next;
        c_reg    <= c_next;
        prod_reg <= prod_next;
        w1_reg   <= w1_next;
        w2_reg   <= w2_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        un_reg   <= un_next;
        ud_reg   <= ud_next;
        zero_reg <= zero_next;
    end

    asw_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ports
    assign s_ready = (state_reg == asw_pkg::ST_IDLE);
    assign m_valid = (state_reg == asw_pkg::ST_OUT);

    always_comb begin
        m_data.cell_i              = (axis_reg == asw_pkg::AXIS_X) ? c_reg : sid_reg[0];
        m_data.cell_j              = (axis_reg == asw_pkg::AXIS_Y) ? c_reg : sid_reg[1];
        m_data.cell_k              = (axis_reg == asw_pkg::AXIS_Z) ? c_reg : sid_reg[2];
        m_data.inside_fraction     = asw_pkg::FRAC_OUT_W'(frac_reg[asw_pkg::RAT_INSIDE]);
        m_data.upper_wall_fraction = asw_pkg::FRAC_OUT_W'(frac_reg[asw_pkg::RAT_UPPER]);
        m_data.lower_wall_fraction = asw_pkg::FRAC_OUT_W'(frac_reg[asw_pkg::RAT_LOWER]);
        m_data.last_cell           = (c_reg == hi_c_reg);
    end

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a cell request is pending");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last_cell) |=> s_ready)
        else $error("block not idle after the last cell");

    a_cell_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (c_reg >= lo_c_reg && c_reg <= hi_c_reg))
        else $error("walk index left its range");

    a_div_idle_on_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !div_req.start)
        else $error("divider started while a cell request is pending");

endmodule
